// ----- hdl/rbei_pkg.sv -----
package rbei_pkg;

	localparam int FRAC_BITS_DEF = 16;

	// configuration register indexes
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_TIME = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SUBSTEPS   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_GRAV_X     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_GRAV_Y     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_GRAV_Z     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_GRAV_ON    = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_STATIC     = 3'd6;

	// multiply schedule: spin*dt, force*dt, summed*dt, quaternion terms, squares
	localparam logic [4:0] MI_SPIN      = 5'd0;
	localparam logic [4:0] MI_FORCE     = 5'd3;
	localparam logic [4:0] MI_SUM       = 5'd6;
	localparam logic [4:0] MI_QUAT      = 5'd9;
	localparam logic [4:0] MI_QUAT_LAST = 5'd20;
	localparam logic [4:0] MI_SQR       = 5'd21;

	localparam logic [4:0] DIV_LAST  = 5'd30;
	localparam logic [4:0] ROOT_LAST = 5'd31;
	localparam logic [4:0] SQR_LAST  = 5'd3;

	typedef struct packed {
		logic       capture;
		logic       prep;
		logic       div_step;
		logic       dt_store;
		logic       mul_issue;
		logic [4:0] mul_idx;
		logic       absv;
		logic       shr;
		logic       shl;
		logic       qident;
		logic       sqrt_load;
		logic       sqrt_step;
		logic       qdiv_load;
		logic       qdiv_store;
		logic [1:0] qk;
		logic       sleep_upd;
		logic       out_load;
	} dp_cmd_t;

	typedef struct packed {
		logic body_static;
		logic norm_zero;
		logic norm_hi;
		logic norm_lo;
		logic out_free;
	} dp_sts_t;

	typedef struct packed {
		logic [1:0] h;
		logic [1:0] q;
		logic [1:0] d;
		logic       neg;
	} quat_term_t;

	// one term of omega * q: which half-angle, which quaternion part, target, sign
	function automatic quat_term_t quat_term(input logic [3:0] t);
		quat_term_t r;
		unique case (t)
			4'd0:    r = '{h: 2'd0, q: 2'd1, d: 2'd0, neg: 1'b1};
			4'd1:    r = '{h: 2'd1, q: 2'd2, d: 2'd0, neg: 1'b1};
			4'd2:    r = '{h: 2'd2, q: 2'd3, d: 2'd0, neg: 1'b1};
			4'd3:    r = '{h: 2'd0, q: 2'd0, d: 2'd1, neg: 1'b0};
			4'd4:    r = '{h: 2'd1, q: 2'd3, d: 2'd1, neg: 1'b0};
			4'd5:    r = '{h: 2'd2, q: 2'd2, d: 2'd1, neg: 1'b1};
			4'd6:    r = '{h: 2'd1, q: 2'd0, d: 2'd2, neg: 1'b0};
			4'd7:    r = '{h: 2'd2, q: 2'd1, d: 2'd2, neg: 1'b0};
			4'd8:    r = '{h: 2'd0, q: 2'd3, d: 2'd2, neg: 1'b1};
			4'd9:    r = '{h: 2'd2, q: 2'd0, d: 2'd3, neg: 1'b0};
			4'd10:   r = '{h: 2'd0, q: 2'd2, d: 2'd3, neg: 1'b0};
			4'd11:   r = '{h: 2'd1, q: 2'd1, d: 2'd3, neg: 1'b1};
			default: r = '{h: 2'd0, q: 2'd0, d: 2'd0, neg: 1'b0};
		endcase
		return r;
	endfunction

	function automatic logic signed [32:0] sx33(input logic [31:0] v);
		return {v[31], v};
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
		if (&v[65:31] || ~|v[65:31])
			return v[31:0];
		return v[65] ? 32'sh8000_0000 : 32'sh7fff_ffff;
	endfunction

	function automatic logic signed [31:0] add_sat(input logic signed [31:0] a,
			input logic signed [31:0] b);
		logic signed [32:0] s;
		s = sx33(a) + sx33(b);
		if (s[32] == s[31])
			return s[31:0];
		return s[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
	endfunction

endpackage

// ----- hdl/rigid_body_euler_integrator.sv -----
// Rigid body integrator: one input word is one physics tick of a single body.
// The block holds position, linear velocity, orientation quaternion (Q2.30),
// the previous contact point, a rest timer and the asleep flag, and returns
// one result word per tick with the new position, orientation, velocity and
// sleep flag. A tick runs a restoring divide for the substep time, 21 products
// on one shared 33x33 multiplier, a one-bit-per-cycle shift loop (none to
// thirty shifts) that brings the quaternion magnitudes into range, four
// squares, an integer square root, and four restoring divides for the
// normalized components. A quaternion that steps to zero skips the squares,
// the root and the divides. A static body goes from acceptance straight to
// the result state and answers with its unchanged state. The next word is
// accepted as soon as the controller is idle, even while the previous result
// still waits on the output.
// Configuration writes are single-cycle, by index: frame_time, substep_count,
// gravity_x, gravity_y, gravity_z, gravity_on, body_static; write them only
// while no tick is in flight.
module rigid_body_euler_integrator #(
	parameter int FRAC_BITS = rbei_pkg::FRAC_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [rbei_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]                    cfg_data,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic signed [31:0]             force_x,
	input  logic signed [31:0]             force_y,
	input  logic signed [31:0]             force_z,
	input  logic signed [31:0]             bias_vel_x,
	input  logic signed [31:0]             bias_vel_y,
	input  logic signed [31:0]             bias_vel_z,
	input  logic signed [31:0]             contact_x,
	input  logic signed [31:0]             contact_y,
	input  logic signed [31:0]             contact_z,
	input  logic signed [31:0]             spin_x,
	input  logic signed [31:0]             spin_y,
	input  logic signed [31:0]             spin_z,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic signed [31:0]             pos_x,
	output logic signed [31:0]             pos_y,
	output logic signed [31:0]             pos_z,
	output logic signed [31:0]             quat_w,
	output logic signed [31:0]             quat_x,
	output logic signed [31:0]             quat_y,
	output logic signed [31:0]             quat_z,
	output logic signed [31:0]             vel_x,
	output logic signed [31:0]             vel_y,
	output logic signed [31:0]             vel_z,
	output logic                           sleeping
);
	import rbei_pkg::*;

	dp_cmd_t cmd;
	dp_sts_t sts;

	// sequence the tick: divide, multiply schedule, normalize, sleep update
	rbei_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.cmd      (cmd),
		.sts      (sts)
	);

	// hold the body state, configuration and the shared arithmetic units
	rbei_dp #(
		.FRAC_BITS (FRAC_BITS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.force_x    (force_x),
		.force_y    (force_y),
		.force_z    (force_z),
		.bias_vel_x (bias_vel_x),
		.bias_vel_y (bias_vel_y),
		.bias_vel_z (bias_vel_z),
		.contact_x  (contact_x),
		.contact_y  (contact_y),
		.contact_z  (contact_z),
		.spin_x     (spin_x),
		.spin_y     (spin_y),
		.spin_z     (spin_z),
		.cmd        (cmd),
		.sts        (sts),
		.out_ready  (out_ready),
		.out_valid  (out_valid),
		.pos_x      (pos_x),
		.pos_y      (pos_y),
		.pos_z      (pos_z),
		.quat_w     (quat_w),
		.quat_x     (quat_x),
		.quat_y     (quat_y),
		.quat_z     (quat_z),
		.vel_x      (vel_x),
		.vel_y      (vel_y),
		.vel_z      (vel_z),
		.sleeping   (sleeping)
	);

endmodule

// ----- hdl/rbei_ctrl.sv -----
module rbei_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output rbei_pkg::dp_cmd_t cmd,
	input  rbei_pkg::dp_sts_t sts
);
	import rbei_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE, S_PREP, S_DTDIV, S_DTST, S_MUL, S_MULD, S_ABS, S_NORM,
		S_SQR, S_SQRD, S_RTLD, S_ROOT, S_QLD, S_QDIV, S_QST, S_SLEEP, S_DONE
	} state_t;

	state_t     state_q;
	logic [4:0] cnt_q;
	logic [1:0] k_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			k_q     <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: if (in_valid) state_q <= sts.body_static ? S_DONE : S_PREP;
				S_PREP: begin
					state_q <= S_DTDIV;
					cnt_q   <= '0;
				end
				S_DTDIV: begin
					if (cnt_q == DIV_LAST) state_q <= S_DTST;
					cnt_q <= cnt_q + 5'd1;
				end
				S_DTST: begin
					state_q <= S_MUL;
					cnt_q   <= '0;
				end
				S_MUL: begin
					if (cnt_q == MI_QUAT_LAST) state_q <= S_MULD;
					cnt_q <= cnt_q + 5'd1;
				end
				S_MULD: state_q <= S_ABS;
				S_ABS:  state_q <= S_NORM;
				S_NORM: begin
					priority if (sts.norm_zero) state_q <= S_SLEEP;
					else if (sts.norm_hi || sts.norm_lo) state_q <= S_NORM;
					else begin
						state_q <= S_SQR;
						cnt_q   <= '0;
					end
				end
				S_SQR: begin
					if (cnt_q == SQR_LAST) state_q <= S_SQRD;
					cnt_q <= cnt_q + 5'd1;
				end
				S_SQRD: state_q <= S_RTLD;
				S_RTLD: begin
					state_q <= S_ROOT;
					cnt_q   <= '0;
				end
				S_ROOT: begin
					if (cnt_q == ROOT_LAST) begin
						state_q <= S_QLD;
						k_q     <= '0;
					end
					cnt_q <= cnt_q + 5'd1;
				end
				S_QLD: begin
					state_q <= S_QDIV;
					cnt_q   <= '0;
				end
				S_QDIV: begin
					if (cnt_q == DIV_LAST) state_q <= S_QST;
					cnt_q <= cnt_q + 5'd1;
				end
				S_QST: begin
					state_q <= (k_q == 2'd3) ? S_SLEEP : S_QLD;
					k_q     <= k_q + 2'd1;
				end
				S_SLEEP: state_q <= S_DONE;
				S_DONE:  if (sts.out_free) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready    = 1'b1;
				cmd.capture = in_valid;
			end
			S_PREP:  cmd.prep = 1'b1;
			S_DTDIV: cmd.div_step = 1'b1;
			S_DTST:  cmd.dt_store = 1'b1;
			S_MUL: begin
				cmd.mul_issue = 1'b1;
				cmd.mul_idx   = cnt_q;
			end
			S_ABS: cmd.absv = 1'b1;
			S_NORM: begin
				cmd.qident = sts.norm_zero;
				cmd.shr    = !sts.norm_zero && sts.norm_hi;
				cmd.shl    = !sts.norm_zero && !sts.norm_hi && sts.norm_lo;
			end
			S_SQR: begin
				cmd.mul_issue = 1'b1;
				cmd.mul_idx   = MI_SQR + cnt_q;
			end
			S_RTLD: cmd.sqrt_load = 1'b1;
			S_ROOT: cmd.sqrt_step = 1'b1;
			S_QLD: begin
				cmd.qdiv_load = 1'b1;
				cmd.qk        = k_q;
			end
			S_QDIV: cmd.div_step = 1'b1;
			S_QST: begin
				cmd.qdiv_store = 1'b1;
				cmd.qk         = k_q;
			end
			S_SLEEP: cmd.sleep_upd = 1'b1;
			S_DONE:  cmd.out_load = sts.out_free;
			default: cmd = '0;
		endcase
	end

	a_done_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE && !sts.out_free) |=> state_q == S_DONE)
		else $error("left DONE while the result slot was busy");

	a_zero_quat: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_NORM && sts.norm_zero) |=> state_q == S_SLEEP)
		else $error("zero quaternion did not skip normalization");

	a_static_skip: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE && in_valid && sts.body_static) |=> state_q == S_DONE)
		else $error("static body did not go straight to the result");

endmodule

// ----- hdl/rbei_dp.sv -----
module rbei_dp #(
	parameter int FRAC_BITS = rbei_pkg::FRAC_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [rbei_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [31:0]                      cfg_data,
	input  logic signed [31:0]               force_x,
	input  logic signed [31:0]               force_y,
	input  logic signed [31:0]               force_z,
	input  logic signed [31:0]               bias_vel_x,
	input  logic signed [31:0]               bias_vel_y,
	input  logic signed [31:0]               bias_vel_z,
	input  logic signed [31:0]               contact_x,
	input  logic signed [31:0]               contact_y,
	input  logic signed [31:0]               contact_z,
	input  logic signed [31:0]               spin_x,
	input  logic signed [31:0]               spin_y,
	input  logic signed [31:0]               spin_z,
	input  rbei_pkg::dp_cmd_t                cmd,
	output rbei_pkg::dp_sts_t                sts,
	input  logic                             out_ready,
	output logic                             out_valid,
	output logic signed [31:0]               pos_x,
	output logic signed [31:0]               pos_y,
	output logic signed [31:0]               pos_z,
	output logic signed [31:0]               quat_w,
	output logic signed [31:0]               quat_x,
	output logic signed [31:0]               quat_y,
	output logic signed [31:0]               quat_z,
	output logic signed [31:0]               vel_x,
	output logic signed [31:0]               vel_y,
	output logic signed [31:0]               vel_z,
	output logic                             sleeping
);
	import rbei_pkg::*;

	localparam logic [31:0] JIT        = 32'(((1 << FRAC_BITS) + 2) / 5);
	localparam logic [31:0] REST_LIMIT = 32'(10 << FRAC_BITS);

	// configuration
	logic [30:0]        frame_time_q;
	logic [4:0]         substeps_q;
	logic signed [31:0] grav_q [3];
	logic               grav_on_q;
	logic               static_q;

	// body state
	logic signed [31:0] pos_q [3];
	logic signed [31:0] vel_q [3];
	logic signed [31:0] quat_q [4];
	logic signed [31:0] lastc_q [3];
	logic [31:0]        rest_q;
	logic               asleep_q;

	// work registers
	logic signed [31:0] force_q [3];
	logic signed [31:0] sum_q [3];
	logic signed [31:0] contact_q [3];
	logic signed [31:0] spin_q [3];
	logic signed [31:0] h_q [3];
	logic [30:0]        dt_q;
	logic signed [63:0] qn_q [4];
	logic [63:0]        mag_q [4];
	logic               neg_q [4];
	logic [63:0]        nsum_q;
	logic [63:0]        sq_n_q, sq_res_q, sq_bit_q;
	logic [31:0]        div_rem_q;
	logic [30:0]        div_num_q;
	logic [30:0]        div_quot_q;
	logic [31:0]        div_dsor_q;
	logic signed [65:0] prod_s1;
	logic [4:0]         midx_s1;
	logic               mvld_s1;

	logic signed [31:0] out_pos_q [3];
	logic signed [31:0] out_vel_q [3];
	logic signed [31:0] out_quat_q [4];
	logic               out_sleep_q;

	// combinational helpers
	logic signed [32:0] mul_a, mul_b;
	logic [4:0]         a_off, w_off;
	quat_term_t         qt_a, qt_w;
	logic signed [65:0] shf, shf1;
	logic signed [63:0] qterm;
	logic [63:0]        mor;
	logic [32:0]        rem_sh;
	logic               div_ge;
	logic [63:0]        root_try;
	logic [31:0]        nclamp;
	logic               in_window;
	logic [32:0]        rest_sum;
	logic [31:0]        rest_nx;
	logic               asleep_nx;
	logic signed [33:0] p34, lo34, hi34;

	assign mor = mag_q[0] | mag_q[1] | mag_q[2] | mag_q[3];

	always_comb begin
		sts.body_static = static_q;
		sts.norm_zero   = ~|mor;
		sts.norm_hi     = |mor[63:31];
		sts.norm_lo     = ~mor[30];
		sts.out_free    = !out_valid || out_ready;
	end

	// multiplier operand select
	always_comb begin
		a_off = '0;
		mul_a = '0;
		mul_b = '0;
		qt_a  = quat_term(4'(cmd.mul_idx - MI_QUAT));
		priority if (cmd.mul_idx < MI_FORCE) begin
			a_off = cmd.mul_idx - MI_SPIN;
			mul_a = sx33(spin_q[a_off[1:0]]);
			mul_b = {2'b00, dt_q};
		end else if (cmd.mul_idx < MI_SUM) begin
			a_off = cmd.mul_idx - MI_FORCE;
			mul_a = sx33(force_q[a_off[1:0]]);
			mul_b = {2'b00, dt_q};
		end else if (cmd.mul_idx < MI_QUAT) begin
			a_off = cmd.mul_idx - MI_SUM;
			mul_a = sx33(sum_q[a_off[1:0]]);
			mul_b = {2'b00, dt_q};
		end else if (cmd.mul_idx < MI_SQR) begin
			mul_a = sx33(h_q[qt_a.h]);
			mul_b = sx33(quat_q[qt_a.q]);
		end else begin
			a_off = cmd.mul_idx - MI_SQR;
			mul_a = {2'b00, mag_q[a_off[1:0]][30:0]};
			mul_b = {2'b00, mag_q[a_off[1:0]][30:0]};
		end
	end

	// product writeback decode
	always_comb begin
		shf   = prod_s1 >>> FRAC_BITS;
		shf1  = prod_s1 >>> (FRAC_BITS + 1);
		qterm = shf[63:0];
		qt_w  = quat_term(4'(midx_s1 - MI_QUAT));
		priority if (midx_s1 < MI_FORCE) w_off = midx_s1 - MI_SPIN;
		else if (midx_s1 < MI_SUM) w_off = midx_s1 - MI_FORCE;
		else if (midx_s1 < MI_QUAT) w_off = midx_s1 - MI_SUM;
		else w_off = '0;
	end

	// shared divider and root step
	always_comb begin
		rem_sh   = {div_rem_q, div_num_q[30]};
		div_ge   = rem_sh >= {1'b0, div_dsor_q};
		root_try = sq_res_q + sq_bit_q;
		priority if (substeps_q == 5'd0) nclamp = 32'd1;
		else if (substeps_q > 5'd16) nclamp = 32'd16;
		else nclamp = {27'd0, substeps_q};
	end

	// rest window and sleep timer
	always_comb begin
		in_window = 1'b1;
		for (int i = 0; i < 3; i++) begin
			p34  = 34'(pos_q[i]);
			lo34 = 34'(lastc_q[i]) - $signed({2'b00, JIT});
			hi34 = 34'(lastc_q[i]) + $signed({2'b00, JIT});
			if (p34 < lo34 || p34 > hi34) in_window = 1'b0;
		end
		rest_sum = {1'b0, rest_q} + {2'b00, frame_time_q};
		if (in_window) begin
			rest_nx   = rest_sum[32] ? 32'hffff_ffff : rest_sum[31:0];
			asleep_nx = asleep_q;
		end else begin
			rest_nx   = '0;
			asleep_nx = 1'b0;
		end
		if (rest_nx > REST_LIMIT) asleep_nx = 1'b1;
	end

	// configuration, body state and handshake flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_time_q <= 31'd1092;
			substeps_q   <= 5'd1;
			grav_q[0]    <= 32'sd0;
			grav_q[1]    <= -32'sd642908;
			grav_q[2]    <= 32'sd0;
			grav_on_q    <= 1'b1;
			static_q     <= 1'b0;
			for (int i = 0; i < 3; i++) begin
				pos_q[i]   <= '0;
				vel_q[i]   <= '0;
				lastc_q[i] <= '0;
			end
			quat_q[0] <= 32'sh4000_0000;
			quat_q[1] <= '0;
			quat_q[2] <= '0;
			quat_q[3] <= '0;
			rest_q    <= '0;
			asleep_q  <= 1'b0;
			out_valid <= 1'b0;
			mvld_s1   <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_FRAME_TIME: frame_time_q <= cfg_data[30:0];
					CFG_SUBSTEPS:   substeps_q   <= cfg_data[4:0];
					CFG_GRAV_X:     grav_q[0]    <= cfg_data;
					CFG_GRAV_Y:     grav_q[1]    <= cfg_data;
					CFG_GRAV_Z:     grav_q[2]    <= cfg_data;
					CFG_GRAV_ON:    grav_on_q    <= cfg_data[0];
					CFG_STATIC:     static_q     <= cfg_data[0];
					default: ;
				endcase
			end
			mvld_s1 <= cmd.mul_issue;
			if (mvld_s1) begin
				if (midx_s1 >= MI_FORCE && midx_s1 < MI_SUM)
					vel_q[w_off[1:0]] <= add_sat(vel_q[w_off[1:0]], sat32(shf));
				else if (midx_s1 >= MI_SUM && midx_s1 < MI_QUAT)
					pos_q[w_off[1:0]] <= add_sat(pos_q[w_off[1:0]], sat32(shf));
			end
			if (cmd.qident) begin
				quat_q[0] <= 32'sh4000_0000;
				quat_q[1] <= '0;
				quat_q[2] <= '0;
				quat_q[3] <= '0;
			end
			if (cmd.qdiv_store)
				quat_q[cmd.qk] <= neg_q[cmd.qk] ? -{1'b0, div_quot_q} : {1'b0, div_quot_q};
			if (cmd.sleep_upd) begin
				for (int i = 0; i < 3; i++) lastc_q[i] <= contact_q[i];
				rest_q   <= rest_nx;
				asleep_q <= asleep_nx;
				if (rest_nx > REST_LIMIT)
					for (int i = 0; i < 3; i++) vel_q[i] <= '0;
			end
			if (cmd.out_load) out_valid <= 1'b1;
			else if (out_ready) out_valid <= 1'b0;
		end
	end

	// work registers
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			force_q   <= '{force_x, force_y, force_z};
			sum_q     <= '{bias_vel_x, bias_vel_y, bias_vel_z};
			contact_q <= '{contact_x, contact_y, contact_z};
			spin_q    <= '{spin_x, spin_y, spin_z};
		end
		if (cmd.prep) begin
			for (int i = 0; i < 3; i++) begin
				if (grav_on_q && !asleep_q) force_q[i] <= add_sat(force_q[i], grav_q[i]);
				sum_q[i] <= add_sat(vel_q[i], sum_q[i]);
			end
			for (int j = 0; j < 4; j++) qn_q[j] <= 64'(quat_q[j]);
			nsum_q     <= '0;
			div_rem_q  <= '0;
			div_num_q  <= frame_time_q;
			div_quot_q <= '0;
			div_dsor_q <= nclamp;
		end
		if (cmd.div_step) begin
			div_rem_q  <= div_ge ? 32'(rem_sh - {1'b0, div_dsor_q}) : rem_sh[31:0];
			div_num_q  <= {div_num_q[29:0], 1'b0};
			div_quot_q <= {div_quot_q[29:0], div_ge};
		end
		if (cmd.dt_store) dt_q <= div_quot_q;
		if (cmd.mul_issue) begin
			prod_s1 <= mul_a * mul_b;
			midx_s1 <= cmd.mul_idx;
		end
		if (mvld_s1) begin
			if (midx_s1 < MI_FORCE)
				h_q[w_off[1:0]] <= sat32(shf1);
			else if (midx_s1 >= MI_QUAT && midx_s1 < MI_SQR)
				qn_q[qt_w.d] <= qt_w.neg ? qn_q[qt_w.d] - qterm : qn_q[qt_w.d] + qterm;
			else if (midx_s1 >= MI_SQR)
				nsum_q <= nsum_q + prod_s1[63:0];
		end
		if (cmd.absv) begin
			for (int j = 0; j < 4; j++) begin
				neg_q[j] <= qn_q[j][63];
				mag_q[j] <= qn_q[j][63] ? 64'(-qn_q[j]) : 64'(qn_q[j]);
			end
		end
		if (cmd.shr) for (int j = 0; j < 4; j++) mag_q[j] <= mag_q[j] >> 1;
		if (cmd.shl) for (int j = 0; j < 4; j++) mag_q[j] <= mag_q[j] << 1;
		if (cmd.sqrt_load) begin
			sq_n_q   <= nsum_q;
			sq_res_q <= '0;
			sq_bit_q <= 64'h4000_0000_0000_0000;
		end
		if (cmd.sqrt_step) begin
			if (sq_n_q >= root_try) begin
				sq_n_q   <= sq_n_q - root_try;
				sq_res_q <= (sq_res_q >> 1) + sq_bit_q;
			end else begin
				sq_res_q <= sq_res_q >> 1;
			end
			sq_bit_q <= sq_bit_q >> 2;
		end
		if (cmd.qdiv_load) begin
			// upper bits of mag are below the root, so start with them as remainder
			div_rem_q  <= {2'b00, mag_q[cmd.qk][30:1]};
			div_num_q  <= {mag_q[cmd.qk][0], 30'd0};
			div_quot_q <= '0;
			div_dsor_q <= sq_res_q[31:0];
		end
		if (cmd.out_load) begin
			out_pos_q   <= pos_q;
			out_vel_q   <= vel_q;
			out_quat_q  <= quat_q;
			out_sleep_q <= asleep_q;
		end
	end

	assign pos_x    = out_pos_q[0];
	assign pos_y    = out_pos_q[1];
	assign pos_z    = out_pos_q[2];
	assign vel_x    = out_vel_q[0];
	assign vel_y    = out_vel_q[1];
	assign vel_z    = out_vel_q[2];
	assign quat_w   = out_quat_q[0];
	assign quat_x   = out_quat_q[1];
	assign quat_y   = out_quat_q[2];
	assign quat_z   = out_quat_q[3];
	assign sleeping = out_sleep_q;

	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_step |-> div_dsor_q != '0)
		else $error("divider stepped with a zero divisor");

	a_norm_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.sqrt_load |-> (~|mor[63:31] && mor[30]))
		else $error("magnitudes not normalized before the root");

	a_quot_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.qdiv_store |-> div_quot_q <= 31'h4000_0000)
		else $error("quaternion component above one");

endmodule
